// ----- src/spi_adc_channel_reader_assert.svh -----
// Assertion macros shared by the checker of the serial converter reader.
`ifndef SPI_ADC_CHANNEL_READER_ASSERT_SVH
`define SPI_ADC_CHANNEL_READER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SACR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sacr check failed");

// Antecedent implies consequent in the next cycle.
`define SACR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sacr check failed");

`endif

// ----- src/sacr_pkg.sv -----
// Types and constants of the serial converter channel reader.
package sacr_pkg;

	localparam int unsigned COMMAND_BITS = 5;
	localparam int unsigned READ_BITS    = 13;
	localparam int unsigned HALF_W       = 16;
	localparam int unsigned RAW_W        = 12;
	localparam int unsigned SCALED_W     = 10;
	localparam int unsigned CODE_W       = 4;

	localparam logic [HALF_W-1:0]       HALF_PERIOD_RST = 16'd400;
	localparam logic [COMMAND_BITS-1:0] CMD_START_BIT   = 5'h10;

	typedef struct packed {
		logic              start_req;
		logic [CODE_W-1:0] channel_code;
		logic              data_in;
	} sacr_in_t;

	// Sequencer result before scaling.
	typedef struct packed {
		logic             chip_select;
		logic             serial_clock;
		logic             data_out;
		logic             data_drive;
		logic             busy_res;
		logic             done_res;
		logic [RAW_W-1:0] raw_value;
	} sacr_res_t;

	typedef struct packed {
		logic                chip_select;
		logic                serial_clock;
		logic                data_out;
		logic                data_drive;
		logic                busy_res;
		logic                done_res;
		logic [RAW_W-1:0]    raw_value;
		logic [SCALED_W-1:0] scaled_value;
	} sacr_out_t;

endpackage

// ----- src/sacr_seq.sv -----
// Transaction sequencer: one tick per accepted item, serial clock and shift registers.
module sacr_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sacr_pkg::HALF_W-1:0]      cfg_data,
	input  logic                             step,
	input  sacr_pkg::sacr_in_t               item,
	output sacr_pkg::sacr_res_t              res
);
	import sacr_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMD  = 2'd1;
	localparam logic [1:0] PH_GAP  = 2'd2;
	localparam logic [1:0] PH_READ = 2'd3;

	logic [HALF_W-1:0]       half_q;
	logic [1:0]              phase_q, phase_n;
	logic [3:0]              bit_q, bit_n, bit_inc;
	logic [HALF_W-1:0]       tick_q, tick_n;
	logic [COMMAND_BITS-1:0] cmd_q, cmd_n;
	logic [READ_BITS-1:0]    smp_q, smp_n;
	logic                    sclk_q, sclk_n;
	logic [RAW_W-1:0]        held_q, held_n;
	logic                    done;
	logic [HALF_W-1:0]       hp;
	logic [HALF_W:0]         tick_sum;
	logic                    tick_last;

	// A zero half period runs as one tick.
	assign hp        = (half_q == '0) ? HALF_W'(1) : half_q;
	assign tick_sum  = {1'b0, tick_q} + (HALF_W+1)'(1);
	assign tick_last = !(tick_sum < {1'b0, hp});
	assign bit_inc   = bit_q + 4'd1;

	always_comb begin
		phase_n = phase_q;
		bit_n   = bit_q;
		tick_n  = tick_q;
		cmd_n   = cmd_q;
		smp_n   = smp_q;
		sclk_n  = sclk_q;
		held_n  = held_q;
		done    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.start_req) begin
				phase_n = PH_CMD;
				cmd_n   = CMD_START_BIT | {1'b0, item.channel_code};
				bit_n   = '0;
				tick_n  = '0;
				sclk_n  = 1'b0;
				smp_n   = '0;
			end
		end else if (!tick_last) begin
			tick_n = tick_sum[HALF_W-1:0];
		end else begin
			tick_n = '0;
			unique case (phase_q)
				PH_CMD: begin
					if (!sclk_q) begin
						sclk_n = 1'b1;
					end else begin
						// falling edge: advance to the next command bit
						sclk_n = 1'b0;
						cmd_n  = {cmd_q[COMMAND_BITS-2:0], 1'b0};
						bit_n  = bit_inc;
						if (bit_inc >= 4'(COMMAND_BITS)) begin
							phase_n = PH_GAP;
							bit_n   = '0;
						end
					end
				end
				PH_GAP: begin
					sclk_n  = 1'b1;
					phase_n = PH_READ;
					smp_n   = '0;
				end
				PH_READ: begin
					if (sclk_q) begin
						sclk_n = 1'b0;
					end else begin
						// end of low half: sample the data line
						smp_n = {smp_q[READ_BITS-2:0], item.data_in};
						bit_n = bit_inc;
						if (bit_inc >= 4'(READ_BITS)) begin
							held_n  = smp_n[RAW_W-1:0];
							phase_n = PH_IDLE;
							bit_n   = '0;
							done    = 1'b1;
						end else begin
							sclk_n = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.chip_select  = (phase_n == PH_IDLE);
		res.serial_clock = (phase_n != PH_IDLE) && sclk_n;
		res.data_out     = (phase_n == PH_CMD) && cmd_n[COMMAND_BITS-1];
		res.data_drive   = (phase_n == PH_CMD);
		res.busy_res     = (phase_n != PH_IDLE);
		res.done_res     = done;
		res.raw_value    = held_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RST;
		end else if (cfg_we) begin
			half_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			tick_q  <= '0;
			cmd_q   <= '0;
			smp_q   <= '0;
			sclk_q  <= 1'b0;
			held_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			tick_q  <= tick_n;
			cmd_q   <= cmd_n;
			smp_q   <= smp_n;
			sclk_q  <= sclk_n;
			held_q  <= held_n;
		end
	end

endmodule

// ----- src/spi_adc_channel_reader.sv -----
// Serial converter channel reader: a bit-banged master for a 12-bit converter, stepped
// one tick per input item. It takes one item every cycle while in_stall is low; the
// result for an item sits in the output register from the cycle after it is accepted
// and is held while out_stall is high, during which in_stall is raised. Each item is
// one tick of the serial timing: a start request while idle opens a transaction of five
// command bits (low half then high half each), one low gap half and thirteen read clocks,
// every half lasting half_period ticks (zero counts as one). The sequencer updates its
// state in the same cycle it accepts the item, so the rate is set by nothing but the
// output register. scaled_value is raw_value*1023/4095, formed from the output register
// by a shift-subtract and a reciprocal step with no divider.
module spi_adc_channel_reader (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sacr_pkg::HALF_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sacr_pkg::sacr_in_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sacr_pkg::sacr_out_t          out_data
);
	import sacr_pkg::*;

	localparam int unsigned PROD_W = RAW_W + SCALED_W;

	sacr_res_t         res;
	sacr_res_t         res_q;
	logic              out_valid_q;
	logic              accept;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_adj;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	sacr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.step     (accept),
		.item     (in_data),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	// raw*1023, then divide by 4095 as (p + p/4096 + 1) / 4096; the sum stays below 2^22
	assign prod     = ({res_q.raw_value, {SCALED_W{1'b0}}}) - PROD_W'(res_q.raw_value);
	assign prod_adj = prod + PROD_W'(prod[PROD_W-1:RAW_W]) + PROD_W'(1);

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.chip_select  = res_q.chip_select;
		out_data.serial_clock = res_q.serial_clock;
		out_data.data_out     = res_q.data_out;
		out_data.data_drive   = res_q.data_drive;
		out_data.busy_res     = res_q.busy_res;
		out_data.done_res     = res_q.done_res;
		out_data.raw_value    = res_q.raw_value;
		out_data.scaled_value = prod_adj[PROD_W-1:RAW_W];
	end

endmodule

// ----- src/sacr_checker.sv -----
// Port-level checks of the serial converter channel reader, bound to the top level.
`include "spi_adc_channel_reader_assert.svh"

module sacr_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  sacr_pkg::sacr_out_t          out_data
);
	import sacr_pkg::*;

	// every accepted item leaves a result behind
	`SACR_ASSERT_NEXT(a_item_gives_result, in_valid && !in_stall, out_valid)
	// no item enters while a result is held back
	`SACR_ASSERT_NOW(a_no_accept_when_blocked, out_valid && out_stall, in_stall)
	// a held result does not move
	`SACR_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_data))
	// done closes the transaction: bus released, clock low
	`SACR_ASSERT_NOW(a_done_releases_bus, out_valid && out_data.done_res,
		out_data.chip_select && !out_data.busy_res && !out_data.data_drive &&
		!out_data.serial_clock)

endmodule

bind spi_adc_channel_reader sacr_checker u_sacr_checker (.*);
